// ===== src/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes for the bitmap slot allocator: request and result
// words, the operation code and the pool update command.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int unsigned IDX_MAX_W = 8;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                  operation;
        logic                 pool;
        logic [7:0]           free_index;
    } t_req;

    typedef struct packed {
        logic                 done_res;
        logic [6:0]           slot_index;
        logic [7:0]           used_count;
    } t_res;

    typedef struct packed {
        logic                 en;
        logic                 pool;
        logic                 set;
        logic [IDX_MAX_W-1:0] idx;
    } t_upd;

endpackage

// ===== src/bsa_prio_enc.sv =====
// ----------------------------------------------------------------------------
// bsa_prio_enc
// Priority encoder: index of the highest set bit of a request vector.
// ----------------------------------------------------------------------------
module bsa_prio_enc #(
    parameter int unsigned SLOTS = 128,
    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS-1:0] i_vec,
    output logic             o_found,
    output logic [IDX_W-1:0] o_idx
);

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int unsigned i = 0; i < SLOTS; i++) begin
            if (i_vec[i]) begin
                o_found = 1'b1;
                o_idx   = IDX_W'(i);
            end
        end
    end

endmodule

// ===== src/bsa_pool_store.sv =====
// ----------------------------------------------------------------------------
// bsa_pool_store
// Allocation bitmaps and used-slot counts of both pools, with read of the
// selected pool and a single set/clear update per cycle.
// ----------------------------------------------------------------------------
module bsa_pool_store #(
    parameter int unsigned SLOTS = 128,
    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int unsigned CNT_W = $clog2(SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsa_pkg::t_upd     i_upd,
    input  logic              i_rd_pool,
    output logic [SLOTS-1:0]  o_map,
    output logic [CNT_W-1:0]  o_cnt
);

    logic [SLOTS-1:0] r_map [2];
    logic [CNT_W-1:0] r_cnt [2];
    logic [IDX_W-1:0] upd_idx;

    assign upd_idx = i_upd.idx[IDX_W-1:0];
    assign o_map   = r_map[i_rd_pool];
    assign o_cnt   = r_cnt[i_rd_pool];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map[0] <= '0;
            r_map[1] <= '0;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
        end else if (i_upd.en) begin
            if (i_upd.set) begin
                r_map[i_upd.pool][upd_idx] <= 1'b1;
                r_cnt[i_upd.pool]          <= r_cnt[i_upd.pool] + CNT_W'(1);
            end else begin
                r_map[i_upd.pool][upd_idx] <= 1'b0;
                r_cnt[i_upd.pool]          <= r_cnt[i_upd.pool] - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Two-pool bitmap allocator: allocate grants the highest free slot, free
// releases a used slot; every request answers with one result word.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is low whenever reset is released.
// The 128-slot priority encode and bitmap update sit between the request
// register and the result register, so back-to-back requests see each other.
// Reset is synchronous: all slots free, counts zero, pipeline empty.
// The receiver cannot stall; o_res_valid strobes for one cycle per request.
module bitmap_slot_allocator #(
    parameter int unsigned SLOTS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bsa_pkg::t_req i_req,
    output logic          o_res_valid,
    output bsa_pkg::t_res o_res
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);

    logic             r_req_valid;
    bsa_pkg::t_req    r_req;
    logic             r_res_valid;
    bsa_pkg::t_res    r_res;
    bsa_pkg::t_res    n_res;
    bsa_pkg::t_upd    upd;

    logic [SLOTS-1:0] cur_map;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic             enc_found;
    logic [IDX_W-1:0] enc_idx;
    logic             is_alloc;
    logic             in_range;
    logic             free_hit;
    logic             done;

    assign busy = ~i_rst_n;

    bsa_pool_store #(.SLOTS(SLOTS)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_rd_pool (r_req.pool),
        .o_map     (cur_map),
        .o_cnt     (cur_cnt)
    );

    bsa_prio_enc #(.SLOTS(SLOTS)) u_enc (
        .i_vec   (~cur_map),
        .o_found (enc_found),
        .o_idx   (enc_idx)
    );

    always_comb begin
        is_alloc = (r_req.operation == bsa_pkg::OP_ALLOC);
        in_range = ({1'b0, r_req.free_index} < 9'(SLOTS));
        free_hit = in_range && cur_map[r_req.free_index[IDX_W-1:0]];
        done     = is_alloc ? enc_found : free_hit;

        upd.en   = r_req_valid && done;
        upd.pool = r_req.pool;
        upd.set  = is_alloc;
        upd.idx  = is_alloc ? bsa_pkg::IDX_MAX_W'(enc_idx) : r_req.free_index;

        if (!done) begin
            new_cnt = cur_cnt;
        end else if (is_alloc) begin
            new_cnt = cur_cnt + CNT_W'(1);
        end else begin
            new_cnt = cur_cnt - CNT_W'(1);
        end

        n_res.done_res   = done;
        n_res.slot_index = (is_alloc && enc_found) ? 7'(enc_idx) : 7'd0;
        n_res.used_count = 8'(new_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
            r_res_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (r_req_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== src/bsa_chk.sv =====
// ----------------------------------------------------------------------------
// bsa_chk
// Port-level checker for the bitmap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_chk #(
    parameter int unsigned SLOTS = 128
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input bsa_pkg::t_req i_req,
    input logic          o_res_valid,
    input bsa_pkg::t_res o_res
);

    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_res_valid)
        else $error("accepted request got no result word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start && !busy, 2))
        else $error("result word without a request");

    a_free_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && $past(i_req.operation, 2) == bsa_pkg::OP_FREE)
            |-> (o_res.slot_index == 7'd0))
        else $error("free result carries a slot index");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.done_res && $past(i_req.operation, 2) == bsa_pkg::OP_ALLOC)
            |-> (o_res.used_count == 8'(SLOTS) && o_res.slot_index == 7'd0))
        else $error("failed allocate on a pool that is not full");

endmodule

bind bitmap_slot_allocator bsa_chk #(.SLOTS(SLOTS)) u_bsa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the two-pool bitmap slot allocator. A clocked driver feeds request
// words from a pending queue and updates a local copy of both bitmaps and
// counts as each word is accepted. A clocked monitor compares every result
// word, field by field, with the oldest predicted one. Directed words cover
// the boundaries; random bursts fill, hold full and drain each pool under
// changing sender idle rates.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS      = 128;
    localparam int LATENCY    = 2;
    localparam int STALL_MAX  = 2000;

    typedef struct {
        bsa_pkg::t_req req;
        bit            drain_first;
    } t_pending_word;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    bsa_pkg::t_req i_req   = '0;
    logic          o_res_valid;
    bsa_pkg::t_res o_res;

    t_pending_word pending_q[$];
    bsa_pkg::t_res expected_res_q[$];

    logic [SLOTS-1:0] slot_map [2];
    int unsigned      used_cnt [2];

    int words_sent   = 0;
    int fail_cnt     = 0;
    int stall_cycles = 0;
    int idle_pct;

    bitmap_slot_allocator #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bsa_pkg::t_res apply_request(bsa_pkg::t_req req);
        bsa_pkg::t_res r;
        bit            found;
        r = '0;
        found = 1'b0;
        if (req.operation == bsa_pkg::OP_ALLOC) begin
            for (int s = SLOTS - 1; s >= 0; s--) begin
                if (!found && !slot_map[req.pool][s]) begin
                    found = 1'b1;
                    slot_map[req.pool][s] = 1'b1;
                    used_cnt[req.pool] = used_cnt[req.pool] + 1;
                    r.done_res = 1'b1;
                    r.slot_index = 7'(s);
                end
            end
        end else if (req.free_index < SLOTS && slot_map[req.pool][req.free_index]) begin
            slot_map[req.pool][req.free_index] = 1'b0;
            used_cnt[req.pool] = used_cnt[req.pool] - 1;
            r.done_res = 1'b1;
        end
        r.used_count = 8'(used_cnt[req.pool]);
        return r;
    endfunction

    task automatic queue_word(bsa_pkg::t_op op, logic pool, logic [7:0] idx,
                              bit drain_first);
        t_pending_word w;
        w.req.operation  = op;
        w.req.pool       = pool;
        w.req.free_index = idx;
        w.drain_first    = drain_first;
        pending_q.push_back(w);
    endtask

    // pool_sel 2 picks a random pool per word
    task automatic queue_burst(int n, int alloc_pct, int pool_sel, bit drain_first);
        bsa_pkg::t_op op;
        logic         pool;
        logic [7:0]   idx;
        for (int k = 0; k < n; k++) begin
            op   = ($urandom_range(0, 99) < alloc_pct) ? bsa_pkg::OP_ALLOC
                                                       : bsa_pkg::OP_FREE;
            pool = (pool_sel == 2) ? 1'($urandom_range(0, 1)) : 1'(pool_sel);
            if (op == bsa_pkg::OP_FREE && $urandom_range(0, 99) < 85)
                idx = 8'($urandom_range(0, SLOTS - 1));
            else
                idx = 8'($urandom_range(0, 255));
            queue_word(op, pool, idx, drain_first && k == 0);
        end
    endtask

    always_comb begin
        case ((words_sent / 100) % 4)
            1: idle_pct = 82;
            3: idle_pct = 33;
            default: idle_pct = 0;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (start && !busy) begin
                expected_res_q.push_back(apply_request(i_req));
                words_sent = words_sent + 1;
            end
            if (!start || !busy) begin
                if (pending_q.size() != 0
                        && !(pending_q[0].drain_first && expected_res_q.size() != 0)
                        && $urandom_range(0, 99) >= idle_pct) begin
                    start <= 1'b1;
                    i_req <= pending_q[0].req;
                    pending_q.delete(0);
                end else begin
                    start <= 1'b0;
                    i_req <= bsa_pkg::t_req'(10'($urandom_range(0, 1023)));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        bsa_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            if (expected_res_q.size() == 0) begin
                $error("unexpected result word: %h", o_res);
                fail_cnt++;
            end else begin
                want = expected_res_q.pop_front();
                if (o_res.done_res !== want.done_res) begin
                    $error("done_res expected %0d got %0d", want.done_res, o_res.done_res);
                    fail_cnt++;
                end
                if (o_res.slot_index !== want.slot_index) begin
                    $error("slot_index expected %0d got %0d",
                           want.slot_index, o_res.slot_index);
                    fail_cnt++;
                end
                if (o_res.used_count !== want.used_count) begin
                    $error("used_count expected %0d got %0d",
                           want.used_count, o_res.used_count);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        slot_map[0] = '0;
        slot_map[1] = '0;
        used_cnt[0] = 0;
        used_cnt[1] = 0;

        queue_word(bsa_pkg::OP_ALLOC, 1'b0, 8'h00, 1'b0);
        queue_word(bsa_pkg::OP_ALLOC, 1'b0, 8'h00, 1'b0);
        queue_word(bsa_pkg::OP_ALLOC, 1'b1, 8'h00, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b0, 8'd127, 1'b0);
        queue_word(bsa_pkg::OP_ALLOC, 1'b0, 8'h55, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b0, 8'd0, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b1, 8'd128, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b1, 8'd255, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b0, 8'd126, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b0, 8'd126, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b1, 8'd127, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b1, 8'd127, 1'b0);
        queue_word(bsa_pkg::OP_ALLOC, 1'b1, 8'hFF, 1'b0);
        queue_word(bsa_pkg::OP_ALLOC, 1'b0, 8'hAA, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b0, 8'h7F, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b0, 8'h80, 1'b0);
        queue_word(bsa_pkg::OP_FREE,  1'b1, 8'h7F, 1'b0);

        // fill, hold full, drain: main pool, then sub pool
        queue_burst(60, 50, 2, 1'b1);
        queue_burst(170, 95, 0, 1'b0);
        queue_burst(40, 70, 0, 1'b0);
        queue_burst(130, 10, 0, 1'b0);
        queue_burst(170, 95, 1, 1'b0);
        queue_burst(80, 50, 2, 1'b1);
        queue_burst(100, 15, 1, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start) @(posedge i_clk);
        while (expected_res_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (fail_cnt == 0 && expected_res_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
